/* rtl/md5_pkg.sv */
// MD5 stream hasher package: shared types, constants and round tables.
// No dependencies; imported by every module of the hasher.
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // Command from front end to compression engine.
  typedef struct packed {
    logic [511:0] block;   // 16 words, word 0 in bits 31:0
    logic         last;    // emit digest after this block
  } md5_cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_FINAL,
    ENG_EMIT
  } md5_eng_state_t;

  typedef enum logic [1:0] {
    FE_FILL,
    FE_PAD2
  } md5_fe_state_t;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/md5_front.sv */
// MD5 front end: packs bytes into a block buffer, adds padding and length.
// Depends on md5_pkg; feeds md5_cmd_t blocks to the block queue.
`default_nettype none
module md5_front
  import md5_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic     byte_present,
  input  wire logic     message_end,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output md5_cmd_t      cmd
);

  logic [511:0]  buf_block;
  logic [5:0]    fill_offset;
  logic [60:0]   byte_count;
  md5_fe_state_t state, state_next;
  logic          full_pad;   // second block must start with the pad byte
  logic [60:0]   count_next;
  logic [63:0]   len_bits;
  logic [5:0]    pos;
  logic [6:0]    used;
  logic          full;
  logic          need2;
  logic          accept;
  logic [511:0]  blk;

  assign in_ready   = (state == FE_FILL) && cmd_ready;
  assign accept     = in_valid && in_ready;
  assign pos        = fill_offset;
  // bytes used in the block after this item's byte
  assign used       = 7'(pos) + 7'(byte_present);
  assign full       = byte_present && (fill_offset == 6'd63);
  assign need2      = !full && (used > 7'd55);
  // in the pad state the count already holds the last byte
  assign count_next = byte_count + 61'(byte_present && (state == FE_FILL));
  assign len_bits   = {count_next, 3'b000};

  // Combine current buffer with this item's byte and padding into a block.
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (state == FE_PAD2) begin
        blk[8*i +: 8] = (i == 0 && full_pad) ? PAD_BYTE : 8'h00;
      end else if (i < int'(pos)) begin
        blk[8*i +: 8] = buf_block[8*i +: 8];
      end else if (i == int'(pos) && byte_present) begin
        blk[8*i +: 8] = data_byte;
      end else if (message_end && !full) begin
        blk[8*i +: 8] = (i == int'(used)) ? PAD_BYTE : 8'h00;
      end else begin
        blk[8*i +: 8] = buf_block[8*i +: 8];
      end
    end
    // length goes in the last eight bytes of the closing block
    if (state == FE_PAD2 || (message_end && !full && !need2)) blk[511:448] = len_bits;
  end

  always_comb begin
    state_next = state;
    cmd.block  = blk;
    cmd.last   = 1'b0;
    cmd_valid  = 1'b0;
    unique case (state)
      FE_FILL: begin
        if (accept && (full || message_end)) begin
          cmd_valid = 1'b1;
          cmd.last  = message_end && !full && !need2;
          if (message_end && (full || need2)) state_next = FE_PAD2;
        end
      end
      default: begin
        cmd_valid = 1'b1;
        cmd.last  = 1'b1;
        if (cmd_ready) state_next = FE_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FE_FILL;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept && byte_present) buf_block[8*pos +: 8] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_offset <= '0;
      byte_count  <= '0;
      full_pad    <= 1'b0;
    end else if (state == FE_PAD2) begin
      if (cmd_ready) begin
        fill_offset <= '0;
        byte_count  <= '0;
        full_pad    <= 1'b0;
      end
    end else if (accept) begin
      if (message_end && (full || need2)) begin
        // data block went out; pad goes in a fresh block
        byte_count <= count_next;
        full_pad   <= full;
      end else if (message_end) begin
        fill_offset <= '0;
        byte_count  <= '0;
      end else begin
        fill_offset <= 6'(used);
        byte_count  <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/md5_queue.sv */
// Two-entry block queue between the MD5 front end and the engine.
// Depends on md5_pkg for md5_cmd_t.
`default_nettype none
module md5_queue
  import md5_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire md5_cmd_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output md5_cmd_t  rd_data
);

  md5_cmd_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_valid && wr_ready) wr_ptr <= ~wr_ptr;
      if (rd_valid && rd_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule
`default_nettype wire

/* rtl/md5_engine.sv */
// MD5 compression engine: one round per cycle, then digest output.
// Depends on md5_pkg for tables, initial values and md5_cmd_t.
`default_nettype none
module md5_engine
  import md5_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cmd_valid,
  output logic       cmd_ready,
  input  wire md5_cmd_t cmd,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [31:0] digest_word,
  output logic [1:0] word_index,
  output logic       last_word
);

  md5_eng_state_t state, state_next;
  logic [31:0] h [4];
  logic [31:0] a, b, c, d;
  logic [511:0] blk;
  logic        last;
  logic [5:0]  rnd;
  logic [1:0]  widx;
  logic [31:0] f, m, t, rot;
  logic [3:0]  g;
  logic [4:0]  s;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (b & d) | (c & ~d); g = 4'(5 * rnd + 1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(3 * rnd + 5); end
      default: begin f = c ^ (b | ~d);    g = 4'(7 * rnd); end
    endcase
    m   = blk[32*g +: 32];
    t   = a + f + m + md5_k(rnd);
    s   = md5_s(rnd);
    rot = (t << s) | (t >> (6'd32 - 6'(s)));
  end

  assign cmd_ready   = (state == ENG_IDLE);
  assign out_valid   = (state == ENG_EMIT);
  assign digest_word = h[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 2'd3);

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE:  if (cmd_valid) state_next = ENG_ROUND;
      ENG_ROUND: if (rnd == 6'd63) state_next = ENG_FINAL;
      ENG_FINAL: state_next = last ? ENG_EMIT : ENG_IDLE;
      default:   if (out_ready && widx == 2'd3) state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ENG_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
      rnd  <= '0;
      widx <= '0;
    end else begin
      unique case (state)
        ENG_IDLE: if (cmd_valid) begin
          blk <= cmd.block;
          last <= cmd.last;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
          rnd <= '0;
        end
        ENG_ROUND: begin
          a <= d; d <= c; c <= b;
          b <= b + rot;
          rnd <= rnd + 6'd1;
        end
        ENG_FINAL: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b;
          h[2] <= h[2] + c; h[3] <= h[3] + d;
          widx <= '0;
        end
        default: if (out_ready) begin
          widx <= widx + 2'd1;
          // back to initial values after word D goes out
          if (widx == 2'd3) begin
            h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/md5_stream_hasher.sv */
// MD5 stream hasher, top level.
// Input channel: in_valid/in_ready with data_byte, byte_present and
// message_end; each item carries at most one message byte. An item with
// message_end closes the message after its own byte.
// Output channel: out_valid/out_ready with digest_word, word_index and
// last_word; four words A..D follow every message end.
// Throughput: one item per cycle while a block fills. A full 64-byte block
// goes through a two-entry queue to the engine, which runs one round per
// cycle: a load, 64 rounds and an add per block. The front end stalls
// while the queue is full, and while it sends the second pad block of a
// message. From the end item, after queued blocks drain, the engine
// hashes one or two padded blocks, then sends four words at one per
// cycle while out_ready is high.
// Reset: chaining words go to the MD5 initial values, counts clear; the
// block buffer holds no reset.
// A stalled receiver holds the current digest word; the engine then
// takes no new block, and the front end backs up once the queue is full.
// Depends on md5_pkg, md5_front, md5_queue, md5_engine.
`default_nettype none
module md5_stream_hasher
  import md5_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        message_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  md5_cmd_t f_cmd, q_cmd;
  logic     f_valid, f_ready, q_valid, q_ready;

  md5_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .byte_present,
    .message_end, .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  md5_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  md5_engine u_engine (
    .clk, .rst, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .digest_word, .word_index, .last_word
  );

endmodule
`default_nettype wire

/* tb/md5_checker.sv */
// Digest checker for the MD5 stream hasher: watches both channels, runs its own
// MD5 over accepted items and compares every digest word in order.
// Depends on nothing but the channel signals handed in by the testbench top.
`timescale 1ns / 100ps
module md5_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        message_end,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] digest_word,
  input  wire logic [1:0]  word_index,
  input  wire logic        last_word,
  output int               fail_count,
  output int               pending_words,
  output int               digest_count
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]  chain [4];
  logic [7:0]   blk_bytes [64];
  logic [60:0]  byte_total;
  logic [5:0]   fill_pos;
  digest_word_t digest_q [$];

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t, m;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d); g = r;
      end else if (r < 32) begin
        f = (b & d) | (c & ~d); g = (5 * r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d; g = (3 * r + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * r) % 16;
      end
      m = {blk_bytes[4*g+3], blk_bytes[4*g+2], blk_bytes[4*g+1], blk_bytes[4*g]};
      t = a + f + m + ROUND_K[r];
      a = d; d = c; c = b;
      b = b + ((t << ROT_AMT[(r / 16) * 4 + r % 4]) | (t >> (32 - ROT_AMT[(r / 16) * 4 + r % 4])));
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic restart_digest();
    chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
    byte_total = '0;
    fill_pos = '0;
  endtask

  task automatic absorb_item(logic [7:0] b, logic present, logic fin);
    logic [63:0] bit_len;
    int pos;
    if (present) begin
      blk_bytes[fill_pos] = b;
      byte_total = byte_total + 1'b1;
      fill_pos = fill_pos + 1'b1;
      if (fill_pos == 0) md5_compress();
    end
    if (fin) begin
      bit_len = {byte_total, 3'b000};
      pos = fill_pos;
      blk_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) blk_bytes[pos++] = 8'h00;
        md5_compress();
        pos = 0;
      end
      while (pos < 56) blk_bytes[pos++] = 8'h00;
      for (int k = 0; k < 8; k++) blk_bytes[56 + k] = bit_len[8*k +: 8];
      md5_compress();
      for (int k = 0; k < 4; k++) digest_q.push_back({chain[k], 2'(k), k == 3});
      restart_digest();
    end
  endtask

  initial begin
    fail_count = 0;
    digest_count = 0;
    pending_words = 0;
    restart_digest();
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) absorb_item(data_byte, byte_present, message_end);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected digest word %h idx %0d", digest_word, word_index);
        end else begin
          want = digest_q.pop_front();
          if (last_word) digest_count++;
          if (digest_word !== want.word || word_index !== want.idx || last_word !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: digest word exp %h/%0d/%0b got %h/%0d/%0b", want.word,
                       want.idx, want.last, digest_word, word_index, last_word);
          end
        end
      end
      pending_words = digest_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Testbench top for the MD5 stream hasher: drives byte items and the
// receiver's ready, and gives the verdict. Depends on md5_checker and the RTL.
`timescale 1ns / 100ps
module testbench;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        message_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;
  int          digest_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  logic        hold_go;
  logic        hold_used;
  int          item_count;

  md5_stream_hasher i_dut (.*);

  md5_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once hold_go is raised.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      out_ready <= 1'b0;
      hold_cycles <= 600;
      hold_used <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(logic [7:0] b, logic present, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    message_end <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  task automatic send_message(int len, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, i == len - 1);
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    byte_present = 1'b0;
    message_end = 1'b0;
    hold_go = 1'b0;
    item_count = 0;
    send_idle_pct = 17;
    recv_idle_pct = 49;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, extreme bytes, empty items, end with no byte
    send_message(0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'haa, 1'b1, 1'b1);
    send_item(8'h55, 1'b1, 1'b1);
    drain_phase();

    // 56 bytes: padding spills into a second block
    send_message(56, 1'b0);
    drain_phase();

    // Long receiver hold-off: a full 64-byte block plus its pad block and
    // two empty messages pile up behind a waiting digest
    hold_go <= 1'b1;
    send_message(3, 1'b0);
    send_message(64, 1'b0);
    send_message(0, 1'b0);
    send_message(0, 1'b0);
    drain_phase();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 17 : 0;
      for (int m = 0; m < 3; m++) begin
        len = $urandom_range(8);
        send_message(len, 1'b1);
      end
      drain_phase();
    end

    repeat (300) @(posedge clk);
    $display("Covered %0d items, %0d digests: empty, two-block pad, full-block messages,",
             item_count, digest_count);
    $display("empty items and a long output stall under three idling mixes.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
